// ===== hdl/utf8v_pkg.sv =====
// utf8v_pkg: shared types and constants of the utf-8 text validator
// register map, mode codes, second-byte range classes, step and result structs
// no dependencies
package utf8v_pkg;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int COUNT_W = 17;
    localparam int MAX_W = 16;

    localparam logic [ADDR_W-3:0] REG_MODE      = 1'b0;
    localparam logic [ADDR_W-3:0] REG_MAX_BYTES = 1'b1;

    localparam logic [1:0] MODE_STRICT = 2'd0;
    localparam logic [1:0] MODE_CRLF   = 2'd1;
    localparam logic [1:0] MODE_LENGTH = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h10000;

    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_DEL   = 8'h7F;
    localparam logic [7:0] LEAD2_LO   = 8'hC2;
    localparam logic [7:0] LEAD2_HI   = 8'hDF;
    localparam logic [7:0] LEAD3_LO   = 8'hE0;
    localparam logic [7:0] LEAD3_SUR  = 8'hED;
    localparam logic [7:0] LEAD3_HI   = 8'hEF;
    localparam logic [7:0] LEAD4_LO   = 8'hF0;
    localparam logic [7:0] LEAD4_HI   = 8'hF4;
    localparam logic [7:0] CONT_LO    = 8'h80;
    localparam logic [7:0] CONT_8F    = 8'h8F;
    localparam logic [7:0] CONT_90    = 8'h90;
    localparam logic [7:0] CONT_9F    = 8'h9F;
    localparam logic [7:0] CONT_A0    = 8'hA0;
    localparam logic [7:0] CONT_HI    = 8'hBF;

    typedef enum logic [2:0] {
        SEC_ANY   = 3'd0,
        SEC_A0_BF = 3'd1,
        SEC_80_9F = 3'd2,
        SEC_90_BF = 3'd3,
        SEC_80_8F = 3'd4
    } t_sec_class;

    typedef struct packed {
        logic [1:0]       mode;
        logic [MAX_W-1:0] max_bytes;
    } t_cfg;

    typedef struct packed {
        logic       take;
        logic       has_byte;
        logic       last;
        logic [7:0] data_byte;
    } t_step;

    typedef struct packed {
        logic               text_ok;
        logic [COUNT_W-1:0] text_length;
    } t_result;

endpackage

// ===== hdl/utf8v_apb_regs.sv =====
// utf8v_apb_regs: apb configuration registers (mode, max_bytes)
// depends on utf8v_pkg
module utf8v_apb_regs
    import utf8v_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [1:0]       r_mode;
    logic [MAX_W-1:0] r_max_bytes;
    logic             wr_en;
    logic [ADDR_W-3:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_STRICT;
            r_max_bytes <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MODE:      r_mode      <= pwdata[1:0];
                REG_MAX_BYTES: r_max_bytes <= pwdata[MAX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MODE:      prdata = {{(DATA_W-2){1'b0}}, r_mode};
            REG_MAX_BYTES: prdata = {{(DATA_W-MAX_W){1'b0}}, r_max_bytes};
            default:       prdata = '0;
        endcase
    end

    assign o_cfg.mode      = r_mode;
    assign o_cfg.max_bytes = r_max_bytes;

endmodule

// ===== hdl/utf8v_byte_check.sv =====
// utf8v_byte_check: per-text sequence state and combinational byte check
// computes the verdict for a closing item; depends on utf8v_pkg
module utf8v_byte_check
    import utf8v_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_step   i_step,
    output t_result o_result
);

    logic [1:0]         r_pending,   n_pending;
    t_sec_class         r_class,     n_class;
    logic               r_failed,    n_failed;
    logic [COUNT_W-1:0] r_count,     n_count;
    logic               r_at_second, n_at_second;

    logic [7:0] b;
    logic       is_cont;
    logic       sec_good;
    logic       good;
    logic       len_bad;
    logic       ok;

    assign b       = i_step.data_byte;
    assign is_cont = (b >= CONT_LO) && (b <= CONT_HI);

    always_comb begin
        unique case (r_class)
            SEC_A0_BF: sec_good = (b >= CONT_A0) && (b <= CONT_HI);
            SEC_80_9F: sec_good = (b >= CONT_LO) && (b <= CONT_9F);
            SEC_90_BF: sec_good = (b >= CONT_90) && (b <= CONT_HI);
            SEC_80_8F: sec_good = (b >= CONT_LO) && (b <= CONT_8F);
            default:   sec_good = is_cont;
        endcase
    end

    always_comb begin
        n_pending   = r_pending;
        n_class     = r_class;
        n_failed    = r_failed;
        n_count     = r_count;
        n_at_second = r_at_second;
        good        = 1'b0;
        if (i_step.has_byte) begin
            if (r_count != COUNT_MAX) begin
                n_count = r_count + 1'b1;
            end
            if (r_pending != 2'd0) begin
                good = r_at_second ? sec_good : is_cont;
                if (!good) begin
                    n_failed  = 1'b1;
                    n_pending = 2'd0;
                end else begin
                    n_pending = r_pending - 2'd1;
                end
                n_at_second = 1'b0;
                n_class     = SEC_ANY;
            end else if (b <= BYTE_DEL) begin
                if (((b < BYTE_SPACE) || (b == BYTE_DEL)) &&
                    !((i_cfg.mode == MODE_CRLF) && ((b == BYTE_CR) || (b == BYTE_LF)))) begin
                    n_failed = 1'b1;
                end
            end else if ((b >= LEAD2_LO) && (b <= LEAD2_HI)) begin
                n_pending   = 2'd1;
                n_class     = (b == LEAD2_LO) ? SEC_A0_BF : SEC_ANY;
                n_at_second = 1'b1;
            end else if ((b >= LEAD3_LO) && (b <= LEAD3_HI)) begin
                n_pending   = 2'd2;
                n_class     = (b == LEAD3_LO) ? SEC_A0_BF :
                              ((b == LEAD3_SUR) ? SEC_80_9F : SEC_ANY);
                n_at_second = 1'b1;
            end else if ((b >= LEAD4_LO) && (b <= LEAD4_HI)) begin
                n_pending   = 2'd3;
                n_class     = (b == LEAD4_LO) ? SEC_90_BF :
                              ((b == LEAD4_HI) ? SEC_80_8F : SEC_ANY);
                n_at_second = 1'b1;
            end else begin
                n_failed = 1'b1;
            end
        end
    end

    assign len_bad = (n_count == '0) || (i_cfg.max_bytes == '0) ||
                     (n_count > {1'b0, i_cfg.max_bytes});
    assign ok      = !n_failed && (n_pending == 2'd0) &&
                     !((i_cfg.mode == MODE_LENGTH) && len_bad);

    assign o_result.text_ok     = ok;
    assign o_result.text_length = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= 2'd0;
            r_class     <= SEC_ANY;
            r_failed    <= 1'b0;
            r_count     <= '0;
            r_at_second <= 1'b0;
        end else if (i_step.take) begin
            if (i_step.last) begin
                r_pending   <= 2'd0;
                r_class     <= SEC_ANY;
                r_failed    <= 1'b0;
                r_count     <= '0;
                r_at_second <= 1'b0;
            end else begin
                r_pending   <= n_pending;
                r_class     <= n_class;
                r_failed    <= n_failed;
                r_count     <= n_count;
                r_at_second <= n_at_second;
            end
        end
    end

endmodule

// ===== hdl/utf8_text_validator_core.sv =====
// utf8_text_validator_core: top level, input register, result register, apb port
// depends on utf8v_pkg, utf8v_apb_regs, utf8v_byte_check
// the item marked last passes the input register, then its verdict enters the result register
// throughput: one item per cycle; a stalled result holds only closing items back
// reset (synchronous, active low) empties both registers, clears text state,
// sets mode to 0 and max_bytes to 0; no clearing pass, ready right after reset
module utf8_text_validator_core
    import utf8v_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_has_byte,
    input  logic               i_last,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_text_ok,
    output logic [COUNT_W-1:0] o_text_length,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    logic               r_a_valid;
    logic [7:0]         r_a_byte;
    logic               r_a_has;
    logic               r_a_last;
    logic               r_out_valid;
    logic               r_text_ok;
    logic [COUNT_W-1:0] r_text_length;

    logic    out_free;
    logic    a_advance;
    logic    in_xfer;
    t_cfg    cfg;
    t_step   step;
    t_result result;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign a_advance  = r_a_valid && (!r_a_last || out_free);
    assign o_in_stall = r_a_valid && !a_advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    utf8v_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign step.take      = a_advance;
    assign step.has_byte  = r_a_has;
    assign step.last      = r_a_last;
    assign step.data_byte = r_a_byte;

    utf8v_byte_check u_check (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (step),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_xfer) begin
            r_a_valid <= 1'b1;
        end else if (a_advance) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_a_byte <= i_data_byte;
            r_a_has  <= i_has_byte;
            r_a_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (a_advance && r_a_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_advance && r_a_last) begin
            r_text_ok     <= result.text_ok;
            r_text_length <= result.text_length;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_text_ok     = r_text_ok;
    assign o_text_length = r_text_length;

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_a_valid)
        else $error("input stalled with empty input register");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_advance && r_a_last) |=> o_out_valid)
        else $error("closing item did not produce a result");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !(a_advance && r_a_last)) |=> !o_out_valid)
        else $error("result appeared without a closing item");

    a_length_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_text_length <= COUNT_MAX))
        else $error("text length above saturation value");

endmodule
